// ===== design/i2cx_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cx_pkg: shared types and constants
// Command classes, queue word layout and sizes for the expander I2C master.
// ----------------------------------------------------------------------------
package i2cx_pkg;

	localparam int NUM_DEVICES = 4;   // devices swept by the multi-device read (1..4)
	localparam int NUM_REGS    = 4;
	localparam int ADDR_W      = 7;
	localparam int DATA_W      = 8;
	localparam int ACCUM_W     = 32;
	localparam int REG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_MULTI = 2'd3;

	// classified tick word, front to back
	typedef struct packed {
		logic              is_cmd;
		logic              is_write;
		logic              is_multi;
		logic [ADDR_W-1:0] device_address;
		logic [DATA_W-1:0] write_data;
		logic              sda_in;
	} item_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

// ===== design/i2cx_front.sv =====
// ----------------------------------------------------------------------------
// i2cx_front: input acceptance and classification
// Decodes the mode of each incoming word and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cx_front import i2cx_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [ADDR_W-1:0]       device_address,
	input  logic [DATA_W-1:0]       write_data,
	input  logic                    sda_in,
	output queue_out_t              q_out,
	input  logic                    q_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            new_item;
	logic             push;
	logic             pop;

	always_comb begin
		new_item.is_cmd         = (mode != MODE_TICK);
		new_item.is_write       = (mode == MODE_WRITE);
		new_item.is_multi       = (mode == MODE_MULTI);
		new_item.device_address = device_address;
		new_item.write_data     = write_data;
		new_item.sda_in         = sda_in;
	end

	assign in_ready    = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push        = in_valid && in_ready;
	assign pop         = q_pop && (count_q != '0);
	assign q_out.valid = (count_q != '0);
	assign q_out.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/i2cx_back.sv =====
// ----------------------------------------------------------------------------
// i2cx_back: bus phase machine and result register
// Advances the I2C phase machine one tick per queued word and registers
// the line levels and status as one result word.
// ----------------------------------------------------------------------------
module i2cx_back import i2cx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  queue_out_t           q_in,
	output logic                 q_pop,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl_level,
	output logic                 sda_pull_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 ack_ok,
	output logic [ACCUM_W-1:0]   read_data
);

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_START     = 4'd1;
	localparam logic [3:0] PH_ADDR      = 4'd2;
	localparam logic [3:0] PH_ADDR_ACK  = 4'd3;
	localparam logic [3:0] PH_WDATA     = 4'd4;
	localparam logic [3:0] PH_WDATA_ACK = 4'd5;
	localparam logic [3:0] PH_RDATA     = 4'd6;
	localparam logic [3:0] PH_NACK      = 4'd7;
	localparam logic [3:0] PH_STOP      = 4'd8;

	localparam logic [1:0] LAST_DEV = 2'(NUM_DEVICES - 1);

	logic [ADDR_W-1:0]  dev_addr_q [NUM_REGS];
	logic [3:0]         phase_q;
	logic [3:0]         bit_count_q;
	logic [1:0]         tick_q;
	logic [DATA_W-1:0]  shift_q;
	logic [1:0]         dev_idx_q;
	logic [ADDR_W-1:0]  cur_addr_q;
	logic               cur_write_q;
	logic               cur_multi_q;
	logic [DATA_W-1:0]  pend_q;
	logic               ack_seen_q;
	logic [ACCUM_W-1:0] accum_q;

	logic [3:0]         phase_d;
	logic [3:0]         bit_count_d;
	logic [1:0]         tick_d;
	logic [DATA_W-1:0]  shift_d;
	logic [1:0]         dev_idx_d;
	logic [ADDR_W-1:0]  cur_addr_d;
	logic               cur_write_d;
	logic               cur_multi_d;
	logic [DATA_W-1:0]  pend_d;
	logic               ack_seen_d;
	logic [ACCUM_W-1:0] accum_d;
	logic               scl_d;
	logic               pull_d;
	logic               done_d;
	logic               fire;
	logic               out_valid_q;

	assign fire      = q_in.valid && (!out_valid_q || out_ready);
	assign q_pop     = fire;
	assign out_valid = out_valid_q;

	always_comb begin
		logic [1:0] t;
		logic       fin;
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		tick_d      = tick_q;
		shift_d     = shift_q;
		dev_idx_d   = dev_idx_q;
		cur_addr_d  = cur_addr_q;
		cur_write_d = cur_write_q;
		cur_multi_d = cur_multi_q;
		pend_d      = pend_q;
		ack_seen_d  = ack_seen_q;
		accum_d     = accum_q;
		scl_d       = 1'b1;
		pull_d      = 1'b0;
		done_d      = 1'b0;

		// command taken only while idle; start runs on the same tick
		if (phase_q == PH_IDLE && q_in.item.is_cmd) begin
			cur_write_d = q_in.item.is_write;
			cur_multi_d = q_in.item.is_multi;
			pend_d      = q_in.item.write_data;
			dev_idx_d   = '0;
			cur_addr_d  = q_in.item.is_multi ? dev_addr_q[0] : q_in.item.device_address;
			ack_seen_d  = 1'b1;
			accum_d     = '0;
			bit_count_d = '0;
			tick_d      = '0;
			shift_d     = '0;
			phase_d     = PH_START;
		end

		t   = tick_d;
		fin = (t == 2'd2);
		if (phase_d != PH_IDLE) begin
			case (phase_d)
				PH_START: begin
					scl_d  = (t < 2'd2);
					pull_d = (t != 2'd0);
				end
				PH_ADDR, PH_WDATA: begin
					scl_d  = (t == 2'd1);
					pull_d = !shift_d[DATA_W-1];
				end
				PH_ADDR_ACK, PH_WDATA_ACK: begin
					scl_d = (t == 2'd1);
					if (t == 2'd1 && q_in.item.sda_in) begin
						ack_seen_d = 1'b0;
					end
				end
				PH_RDATA: begin
					scl_d = (t == 2'd1);
					if (t == 2'd1) begin
						shift_d = {shift_d[DATA_W-2:0], q_in.item.sda_in};
					end
				end
				PH_NACK: begin
					scl_d = (t == 2'd1);
				end
				default: begin
					// stop: SCL rises before SDA is released
					scl_d  = (t != 2'd0);
					pull_d = (t < 2'd2);
				end
			endcase

			tick_d = fin ? 2'd0 : t + 2'd1;
			if (fin) begin
				case (phase_d)
					PH_START: begin
						shift_d     = {cur_addr_d, !cur_write_d};
						bit_count_d = '0;
						phase_d     = PH_ADDR;
					end
					PH_ADDR, PH_WDATA: begin
						shift_d     = {shift_d[DATA_W-2:0], 1'b0};
						bit_count_d = bit_count_d + 4'd1;
						if (bit_count_d >= 4'd8) begin
							phase_d = (phase_d == PH_ADDR) ? PH_ADDR_ACK : PH_WDATA_ACK;
						end
					end
					PH_ADDR_ACK: begin
						bit_count_d = '0;
						if (cur_write_d) begin
							shift_d = pend_d;
							phase_d = PH_WDATA;
						end else begin
							shift_d = '0;
							phase_d = PH_RDATA;
						end
					end
					PH_WDATA_ACK, PH_NACK: begin
						phase_d = PH_STOP;
					end
					PH_RDATA: begin
						bit_count_d = bit_count_d + 4'd1;
						if (bit_count_d >= 4'd8) begin
							case (dev_idx_d)
								2'd0:    accum_d[7:0]   = accum_d[7:0]   | shift_d;
								2'd1:    accum_d[15:8]  = accum_d[15:8]  | shift_d;
								2'd2:    accum_d[23:16] = accum_d[23:16] | shift_d;
								default: accum_d[31:24] = accum_d[31:24] | shift_d;
							endcase
							phase_d = PH_NACK;
						end
					end
					default: begin
						if (cur_multi_d && dev_idx_d < LAST_DEV) begin
							dev_idx_d  = dev_idx_d + 2'd1;
							cur_addr_d = dev_addr_q[dev_idx_d];
							phase_d    = PH_START;
						end else begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q[0] <= 7'd32;
			dev_addr_q[1] <= 7'd33;
			dev_addr_q[2] <= 7'd34;
			dev_addr_q[3] <= 7'd35;
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			tick_q        <= '0;
			shift_q       <= '0;
			dev_idx_q     <= '0;
			cur_addr_q    <= '0;
			cur_write_q   <= 1'b0;
			cur_multi_q   <= 1'b0;
			pend_q        <= '0;
			ack_seen_q    <= 1'b1;
			accum_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				dev_addr_q[cfg_index] <= cfg_data;
			end
			if (fire) begin
				phase_q     <= phase_d;
				bit_count_q <= bit_count_d;
				tick_q      <= tick_d;
				shift_q     <= shift_d;
				dev_idx_q   <= dev_idx_d;
				cur_addr_q  <= cur_addr_d;
				cur_write_q <= cur_write_d;
				cur_multi_q <= cur_multi_d;
				pend_q      <= pend_d;
				ack_seen_q  <= ack_seen_d;
				accum_q     <= accum_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			scl_level    <= scl_d;
			sda_pull_low <= pull_d;
			busy_res     <= (phase_d != PH_IDLE);
			done_res     <= done_d;
			ack_ok       <= ack_seen_d;
			read_data    <= accum_d;
		end
	end

endmodule

// ===== design/i2c_expander_master.sv =====
// ----------------------------------------------------------------------------
// i2c_expander_master: tick-stepped I2C master for 8-bit port expanders
// Writes or reads one expander byte, or reads four expanders into 32 bits.
// ----------------------------------------------------------------------------
// Each input word is one bus tick and yields exactly one result word with the
// SCL level, the SDA pull-down, busy, done, the running ACK status and the
// read data. A word with a nonzero mode starts a transaction when the master
// is idle and is ignored otherwise; its start tick is driven at once. Every
// bit, start, ACK, NACK and stop spans three ticks. The block takes one word
// per clock while the queue has room: the front end decodes words into a
// two-entry queue, and the phase machine retires one queued word per cycle
// into the result register unless a result waits on out_ready; such a wait
// does not hold back input until the queue fills. Expander addresses for the
// four-device read come from registers 0..3 of the write port (reset 32..35)
// and are to be changed only while the master is idle.
module i2c_expander_master import i2cx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [ADDR_W-1:0]    device_address,
	input  logic [DATA_W-1:0]    write_data,
	input  logic                 sda_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl_level,
	output logic                 sda_pull_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 ack_ok,
	output logic [ACCUM_W-1:0]   read_data,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	queue_out_t q_word;   // head of the tick queue
	logic       q_pop;

	// front: accept and classify
	i2cx_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.device_address (device_address),
		.write_data     (write_data),
		.sda_in         (sda_in),
		.q_out          (q_word),
		.q_pop          (q_pop)
	);

	// back: phase machine, address registers, result register
	i2cx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_in         (q_word),
		.q_pop        (q_pop),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scl_level    (scl_level),
		.sda_pull_low (sda_pull_low),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.ack_ok       (ack_ok),
		.read_data    (read_data)
	);

endmodule

// ===== test/tb_i2c_expander_master.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_expander_master: self-checking bench for the expander I2C master
// Feeds bus-tick words through random idle and stall gaps, predicts every
// result word and checks each field in order of arrival.
// ----------------------------------------------------------------------------
module tb_i2c_expander_master import i2cx_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR_0 = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR_1 = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR_2 = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR_3 = 2'd3;

	localparam int NUM_PHASES    = 6;    // config settings swept by the random part
	localparam int PHASE_TICKS   = 150;  // bus ticks per random phase
	localparam int HOLD_CYCLES   = 64;   // long output stall, fills the input queue
	localparam int SETTLE_CYCLES = 4;    // idle wait after all owed words are back
	localparam int DRAIN_CYCLES  = 20;
	// Worst legal gap without any handshake is the long hold plus a sender gap;
	// allow a wide margin.
	localparam int STALL_LIMIT   = 2000;

	// phase machine of the master, as tracked by the predictor
	typedef enum logic [3:0] {
		BUS_IDLE, BUS_START, BUS_ADDR, BUS_ADDR_ACK, BUS_WDATA,
		BUS_WDATA_ACK, BUS_RDATA, BUS_NACK, BUS_STOP
	} bus_phase_t;

	// one result word
	typedef struct packed {
		logic               scl;
		logic               pull;
		logic               busy;
		logic               done;
		logic               ack;
		logic [ACCUM_W-1:0] data;
	} bus_tick_t;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the master's state per accepted word and holds the
	// result words still owed by the block.
	// ------------------------------------------------------------------------
	class i2c_tick_scoreboard;
		bus_phase_t         phase;
		logic [3:0]         bit_cnt;
		logic [1:0]         tick;
		logic [DATA_W-1:0]  shifter;
		logic [1:0]         dev_idx;
		logic [ADDR_W-1:0]  cur_addr;
		logic [1:0]         cur_mode;
		logic [DATA_W-1:0]  pending_byte;
		logic               ack_seen;
		logic [ACCUM_W-1:0] read_accum;
		logic [ADDR_W-1:0]  dev_addr [NUM_REGS];
		bus_tick_t          expected_ticks [$];
		int errors, ticks, results, writes, reads, multis, missed_acks;

		function new();
			dev_addr[0] = 7'd32;
			dev_addr[1] = 7'd33;
			dev_addr[2] = 7'd34;
			dev_addr[3] = 7'd35;
			phase = BUS_IDLE;
			bit_cnt = '0;
			tick = '0;
			shifter = '0;
			dev_idx = '0;
			cur_addr = '0;
			cur_mode = MODE_TICK;
			pending_byte = '0;
			ack_seen = 1'b1;
			read_accum = '0;
		endfunction

		function void set_dev_addr(input logic [REG_IDX_W-1:0] idx,
		                           input logic [ADDR_W-1:0] val);
			dev_addr[idx] = val;
		endfunction

		function bit busy();
			return phase != BUS_IDLE;
		endfunction

		function bit acking();
			return phase == BUS_ADDR_ACK || phase == BUS_WDATA_ACK;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		// Advance one bus tick and queue the word the block must produce.
		function void note_tick(input logic [1:0] m, input logic [ADDR_W-1:0] a,
		                        input logic [DATA_W-1:0] w, input logic s);
			bus_tick_t  r;
			logic [1:0] t;
			logic       last;
			ticks++;
			r = '0;
			r.scl = 1'b1;
			// a command only starts a transaction from idle
			if (phase == BUS_IDLE && m != MODE_TICK) begin
				cur_mode = m;
				pending_byte = w;
				dev_idx = '0;
				cur_addr = (m == MODE_MULTI) ? dev_addr[0] : a;
				ack_seen = 1'b1;
				read_accum = '0;
				bit_cnt = '0;
				tick = '0;
				shifter = '0;
				phase = BUS_START;
				case (m)
					MODE_WRITE: writes++;
					MODE_READ:  reads++;
					default:    multis++;
				endcase
			end
			if (phase != BUS_IDLE) begin
				t = tick;
				case (phase)
					BUS_START: begin
						r.scl = (t < 2);
						r.pull = (t >= 1);
					end
					BUS_ADDR, BUS_WDATA: begin
						r.scl = (t == 1);
						r.pull = !shifter[DATA_W-1];
					end
					BUS_ADDR_ACK, BUS_WDATA_ACK: begin
						r.scl = (t == 1);
						if (t == 1 && s) begin
							if (ack_seen)
								missed_acks++;
							ack_seen = 1'b0;
						end
					end
					BUS_RDATA: begin
						r.scl = (t == 1);
						if (t == 1)
							shifter = {shifter[DATA_W-2:0], s};
					end
					BUS_NACK: r.scl = (t == 1);
					default: begin
						// stop: SCL rises before SDA is released
						r.scl = (t >= 1);
						r.pull = (t < 2);
					end
				endcase
				last = (t >= 2);
				tick = last ? 2'd0 : t + 2'd1;
				if (last) begin
					case (phase)
						BUS_START: begin
							shifter = {cur_addr, (cur_mode == MODE_WRITE) ? 1'b0 : 1'b1};
							bit_cnt = '0;
							phase = BUS_ADDR;
						end
						BUS_ADDR, BUS_WDATA: begin
							shifter = shifter << 1;
							bit_cnt++;
							if (bit_cnt >= 8) begin
								if (phase == BUS_ADDR)
									phase = BUS_ADDR_ACK;
								else
									phase = BUS_WDATA_ACK;
							end
						end
						BUS_ADDR_ACK: begin
							bit_cnt = '0;
							if (cur_mode == MODE_WRITE) begin
								shifter = pending_byte;
								phase = BUS_WDATA;
							end else begin
								shifter = '0;
								phase = BUS_RDATA;
							end
						end
						BUS_WDATA_ACK, BUS_NACK: phase = BUS_STOP;
						BUS_RDATA: begin
							bit_cnt++;
							if (bit_cnt >= 8) begin
								read_accum |= ACCUM_W'(shifter) << (8 * int'(dev_idx));
								phase = BUS_NACK;
							end
						end
						default: begin
							// four-device read walks on to the next expander
							if (cur_mode == MODE_MULTI && int'(dev_idx) + 1 < NUM_DEVICES) begin
								dev_idx++;
								cur_addr = dev_addr[dev_idx];
								phase = BUS_START;
							end else begin
								phase = BUS_IDLE;
								r.done = 1'b1;
							end
						end
					endcase
				end
			end
			r.busy = (phase != BUS_IDLE);
			r.ack = ack_seen;
			r.data = read_accum;
			expected_ticks.push_back(r);
		endfunction

		task report(input string what);
			errors++;
			if (errors <= 100)
				$display("[%0t] MISMATCH result %0d: %s", $realtime, results, what);
		endtask

		task cmp_field(input string name, input logic [ACCUM_W-1:0] got,
		               input logic [ACCUM_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
		endtask

		task check_tick(input bus_tick_t got);
			bus_tick_t want;
			results++;
			if (expected_ticks.size() == 0) begin
				report("result word with nothing outstanding");
				return;
			end
			want = expected_ticks.pop_front();
			cmp_field("scl_level", ACCUM_W'(got.scl), ACCUM_W'(want.scl));
			cmp_field("sda_pull_low", ACCUM_W'(got.pull), ACCUM_W'(want.pull));
			cmp_field("busy_res", ACCUM_W'(got.busy), ACCUM_W'(want.busy));
			cmp_field("done_res", ACCUM_W'(got.done), ACCUM_W'(want.done));
			cmp_field("ack_ok", ACCUM_W'(got.ack), ACCUM_W'(want.ack));
			cmp_field("read_data", got.data, want.data);
		endtask

		task flush_leftovers();
			if (expected_ticks.size() != 0)
				report($sformatf("%0d result words never arrived", expected_ticks.size()));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           mode;
	logic [ADDR_W-1:0]    device_address;
	logic [DATA_W-1:0]    write_data;
	logic                 sda_in;
	logic                 out_valid;
	logic                 out_ready;
	logic                 scl_level;
	logic                 sda_pull_low;
	logic                 busy_res;
	logic                 done_res;
	logic                 ack_ok;
	logic [ACCUM_W-1:0]   read_data;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	i2c_expander_master dut (.*);

	i2c_tick_scoreboard sb = new();

	bit tx_gaps  = 1'b1;   // sender inserts idle cycles between words
	bit rx_gaps  = 1'b1;   // receiver inserts stall cycles between words
	bit hold_req = 1'b0;   // sender asks the receiver for one long stall
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Input side. All drive happens at the falling edge; handshakes are
	// observed at the rising edge, before the block's own updates land.
	// ------------------------------------------------------------------------

	// Offer one bus tick word and wait for it to be taken. Entered and left
	// at a falling edge; valid stays high when the next word follows at once.
	task automatic send_tick(input logic [1:0] m, input logic [ADDR_W-1:0] a,
	                         input logic [DATA_W-1:0] w, input logic s);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		device_address <= a;
		write_data <= w;
		sda_in <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(m, a, w, s);
		@(negedge clk);
	endtask

	// Issue a command from idle, then keep ticking until the master is idle
	// again. Words sent while busy carry random command fields, which the
	// master must ignore. The slave side answers ACK slots with a miss chance
	// of nack_pct percent; read_fill forces read bits (negative: random).
	task automatic bus_transaction(input logic [1:0] m, input logic [ADDR_W-1:0] a,
	                               input logic [DATA_W-1:0] w, input int nack_pct,
	                               input int read_fill);
		logic s;
		send_tick(m, a, w, 1'($urandom_range(0, 1)));
		while (sb.busy()) begin
			if (sb.acking())
				s = ($urandom_range(0, 99) < nack_pct);
			else if (read_fill >= 0)
				s = read_fill[0];
			else
				s = 1'($urandom_range(0, 1));
			send_tick(2'($urandom_range(0, 3)), 7'($urandom), 8'($urandom), s);
		end
	endtask

	// Drop valid and let every owed word come back before touching registers.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_dev_addr(idx, val);
		@(negedge clk);
	endtask

	task automatic set_dev_addrs(input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] a1,
	                             input logic [ADDR_W-1:0] a2, input logic [ADDR_W-1:0] a3);
		put_reg(REG_DEV_ADDR_0, a0);
		put_reg(REG_DEV_ADDR_1, a1);
		put_reg(REG_DEV_ADDR_2, a2);
		put_reg(REG_DEV_ADDR_3, a3);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main stimulus
	// ------------------------------------------------------------------------
	initial begin
		int kind;
		int phase_end;
		int nack_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_TICK;
		device_address = '0;
		write_data = '0;
		sda_in = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEV_ADDR_0;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with the register reset values still in place.
		send_tick(MODE_TICK, '0, '0, 1'b0);             // idle ticks, both SDA levels
		send_tick(MODE_TICK, '1, '1, 1'b1);
		bus_transaction(MODE_WRITE, 7'd0, 8'hFF, 0, -1);     // all ACKed
		bus_transaction(MODE_WRITE, 7'd127, 8'h00, 100, -1); // every ACK missing
		bus_transaction(MODE_READ, 7'd127, 8'h00, 0, 1);     // reads back all ones
		bus_transaction(MODE_READ, 7'd0, 8'hFF, 100, 0);     // address NACK, read still runs
		bus_transaction(MODE_MULTI, 7'd5, 8'h5A, 0, -1);     // four devices at reset addresses
		send_tick(MODE_TICK, '0, '0, 1'b1);

		// Random part: one register setting per phase, extremes included.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				quiesce();
				case (p)
					1: set_dev_addrs('0, '0, '0, '0);
					2: set_dev_addrs('1, '1, '1, '1);
					3: set_dev_addrs(7'd0, 7'd127, 7'd85, 7'd42);
					default: set_dev_addrs(7'($urandom), 7'($urandom),
					                       7'($urandom), 7'($urandom));
				endcase
			end
			phase_end = sb.ticks + PHASE_TICKS;
			if (p == 2) begin
				// back pressure: receiver stalls long while words keep coming
				hold_req = 1'b1;
				tx_gaps = 1'b0;
				bus_transaction(MODE_MULTI, 7'($urandom), 8'($urandom), 0, -1);
			end
			while (sb.ticks < phase_end) begin
				kind = $urandom_range(0, 9);
				tx_gaps = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: nack_pct = 0;
					6, 7, 8:          nack_pct = 3;
					default:          nack_pct = 50;
				endcase
				if (kind == 0)
					repeat ($urandom_range(1, 6))
						send_tick(MODE_TICK, 7'($urandom), 8'($urandom),
						          1'($urandom_range(0, 1)));
				else if (kind <= 3)
					bus_transaction(MODE_WRITE, 7'($urandom), 8'($urandom), nack_pct, -1);
				else if (kind <= 6)
					bus_transaction(MODE_READ, 7'($urandom), 8'($urandom), nack_pct, -1);
				else
					bus_transaction(MODE_MULTI, 7'($urandom), 8'($urandom), nack_pct, -1);
			end
		end

		// Wind down: wait for owed words, then watch a little longer for extras.
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftovers();

		$display("Run covered %0d bus ticks: %0d byte writes, %0d byte reads,",
		         sb.ticks, sb.writes, sb.reads);
		$display("%0d four-device reads, %0d transactions with a missed ACK.",
		         sb.multis, sb.missed_acks);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Output side: random stalls, an occasional gap-free stretch, and one
	// long hold on request from the sender.
	// ------------------------------------------------------------------------
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = rx_gaps ? $urandom_range(0, 5) : 0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_tick('{scl_level, sda_pull_low, busy_res, done_res, ack_ok, read_data});
			if (sb.results % 40 == 0)
				rx_gaps = ($urandom_range(0, 2) != 0);
			@(negedge clk);
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
design/i2cx_pkg.sv
design/i2cx_front.sv
design/i2cx_back.sv
design/i2c_expander_master.sv
test/tb_i2c_expander_master.sv
